FILE: hw/rtl/cvc_pkg.sv
// Shared types and constants for the coffee vending controller.
// Depends on nothing; used by every module under hw/rtl.
package cvc_pkg;

    typedef enum logic [1:0] {
        BREW_WAIT   = 2'd0,
        BREW_CUP    = 2'd1,
        BREW_COFFEE = 2'd2,
        BREW_MILK   = 2'd3
    } t_brew;

    typedef enum logic {
        CASH_COLLECT = 1'b0,
        CASH_HELD    = 1'b1
    } t_cash;

    localparam logic [1:0] CFG_PRICE  = 2'd0;
    localparam logic [1:0] CFG_CUP    = 2'd1;
    localparam logic [1:0] CFG_COFFEE = 2'd2;
    localparam logic [1:0] CFG_MILK   = 2'd3;

    localparam logic [10:0] PRICE_RST  = 11'd50;
    localparam logic [15:0] CUP_RST    = 16'd250;
    localparam logic [15:0] COFFEE_RST = 16'd3000;
    localparam logic [15:0] MILK_RST   = 16'd3000;

    localparam logic [2:0] COIN_NONE = 3'd0;
    localparam logic [2:0] COIN_5C   = 3'd1;
    localparam logic [2:0] COIN_10C  = 3'd2;
    localparam logic [2:0] COIN_20C  = 3'd3;
    localparam logic [2:0] COIN_50C  = 3'd4;
    localparam logic [2:0] COIN_100C = 3'd5;
    localparam logic [2:0] COIN_200C = 3'd6;

    localparam int CHG_KINDS = 6;
    localparam logic [7:0] CHG_VALUE [CHG_KINDS] = '{8'd200, 8'd100, 8'd50, 8'd20, 8'd10, 8'd5};
    localparam logic [2:0] CHG_CODE  [CHG_KINDS] = '{COIN_200C, COIN_100C, COIN_50C,
                                                     COIN_20C, COIN_10C, COIN_5C};
    localparam logic [7:0] MIN_COIN = 8'd5;

    typedef struct packed {
        logic [10:0] price;
        logic [15:0] cup_ticks;
        logic [15:0] coffee_ticks;
        logic [15:0] milk_ticks;
    } t_cfg;

    typedef struct packed {
        logic        cup_on;
        logic        coffee_on;
        logic        milk_on;
        logic        ready_led;
        logic [2:0]  change_coin;
        logic [10:0] credit;
        logic        enough_credit;
    } t_result;

    function automatic logic [7:0] coin_value(input logic [2:0] code);
        logic [7:0] v;
        case (code)
            COIN_5C:   v = 8'd5;
            COIN_10C:  v = 8'd10;
            COIN_20C:  v = 8'd20;
            COIN_50C:  v = 8'd50;
            COIN_100C: v = 8'd100;
            COIN_200C: v = 8'd200;
            default:   v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/cvc_core.sv
// Tick engine: credit, brew sequencer, cash side and change return.
// Depends on cvc_pkg; state advances only on an accepted input transfer.
module cvc_core #(
    parameter int TIME_BITS   = 16,
    parameter int CREDIT_BITS = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_button_press,
    input  logic               i_coin_event,
    input  logic [2:0]         i_coin_code,
    input  cvc_pkg::t_cfg      i_cfg,
    output cvc_pkg::t_result   o_result
);

    localparam int CMPW = (CREDIT_BITS > 11) ? CREDIT_BITS : 11;

    cvc_pkg::t_brew          r_brew, n_brew;
    cvc_pkg::t_cash          r_cash, n_cash;
    logic [CREDIT_BITS-1:0]  r_credit, n_credit;
    logic                    r_reached, n_reached;
    logic                    r_cr_ready, n_cr_ready;
    logic                    r_btn, n_btn;
    logic                    r_charge, n_charge;
    logic [TIME_BITS-1:0]    r_timer, n_timer;
    logic                    r_expired, n_expired;

    logic [CREDIT_BITS:0]    sum;
    logic [CMPW-1:0]         price_x;
    logic [CMPW-1:0]         credit_x;
    logic [TIME_BITS+15:0]   cup_w, coffee_w, milk_w;
    logic [TIME_BITS-1:0]    cup_t, coffee_t, milk_t;
    logic                    found;
    logic [2:0]              coin_out;

    assign cup_w    = {{TIME_BITS{1'b0}}, i_cfg.cup_ticks};
    assign coffee_w = {{TIME_BITS{1'b0}}, i_cfg.coffee_ticks};
    assign milk_w   = {{TIME_BITS{1'b0}}, i_cfg.milk_ticks};
    assign cup_t    = cup_w[TIME_BITS-1:0];
    assign coffee_t = coffee_w[TIME_BITS-1:0];
    assign milk_t   = milk_w[TIME_BITS-1:0];
    assign price_x  = CMPW'(i_cfg.price);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brew     <= cvc_pkg::BREW_WAIT;
            r_cash     <= cvc_pkg::CASH_COLLECT;
            r_credit   <= '0;
            r_reached  <= 1'b0;
            r_cr_ready <= 1'b0;
            r_btn      <= 1'b0;
            r_charge   <= 1'b0;
            r_timer    <= '0;
            r_expired  <= 1'b0;
        end else if (i_accept) begin
            r_brew     <= n_brew;
            r_cash     <= n_cash;
            r_credit   <= n_credit;
            r_reached  <= n_reached;
            r_cr_ready <= n_cr_ready;
            r_btn      <= n_btn;
            r_charge   <= n_charge;
            r_timer    <= n_timer;
            r_expired  <= n_expired;
        end
    end

    always_comb begin
        n_brew     = r_brew;
        n_cash     = r_cash;
        n_credit   = r_credit;
        n_reached  = r_reached;
        n_cr_ready = r_cr_ready;
        n_btn      = r_btn | i_button_press;
        n_charge   = r_charge;
        n_timer    = r_timer;
        n_expired  = r_expired;
        found      = 1'b0;
        coin_out   = cvc_pkg::COIN_NONE;
        sum        = {1'b0, r_credit} + (CREDIT_BITS+1)'(cvc_pkg::coin_value(i_coin_code));
        credit_x   = '0;

        // add coin, saturate
        if (i_coin_event) begin
            n_credit = sum[CREDIT_BITS] ? {CREDIT_BITS{1'b1}} : sum[CREDIT_BITS-1:0];
            if (CMPW'(n_credit) >= price_x) begin
                n_reached = 1'b1;
            end
        end

        // count the phase timer
        if (r_brew != cvc_pkg::BREW_WAIT && !r_expired) begin
            if (r_timer <= TIME_BITS'(1)) begin
                n_timer   = '0;
                n_expired = 1'b1;
            end else begin
                n_timer = r_timer - TIME_BITS'(1);
            end
        end

        case (r_brew)
            cvc_pkg::BREW_WAIT: begin
                if (n_btn && r_cr_ready) begin
                    n_btn      = 1'b0;
                    n_cr_ready = 1'b0;
                    n_brew     = cvc_pkg::BREW_CUP;
                    n_timer    = cup_t;
                    n_expired  = 1'b0;
                end
            end
            cvc_pkg::BREW_CUP: begin
                if (n_expired) begin
                    n_brew    = cvc_pkg::BREW_COFFEE;
                    n_timer   = coffee_t;
                    n_expired = 1'b0;
                end
            end
            cvc_pkg::BREW_COFFEE: begin
                if (n_expired) begin
                    n_brew    = cvc_pkg::BREW_MILK;
                    n_timer   = milk_t;
                    n_expired = 1'b0;
                end
            end
            default: begin
                if (n_expired) begin
                    n_expired = 1'b0;
                    n_brew    = cvc_pkg::BREW_WAIT;
                    n_charge  = 1'b1;
                    credit_x  = CMPW'(n_credit);
                    if (credit_x >= price_x) begin
                        credit_x = credit_x - price_x;
                        n_credit = credit_x[CREDIT_BITS-1:0];
                    end else begin
                        n_credit = '0;
                    end
                end
            end
        endcase

        case (r_cash)
            cvc_pkg::CASH_COLLECT: begin
                if (n_reached) begin
                    n_cr_ready = 1'b1;
                    n_cash     = cvc_pkg::CASH_HELD;
                end
                n_reached = 1'b0;
            end
            default: begin
                if (n_charge) begin
                    // greedy: largest coin that fits
                    for (int k = 0; k < cvc_pkg::CHG_KINDS; k++) begin
                        if (!found && n_credit >= CREDIT_BITS'(cvc_pkg::CHG_VALUE[k])) begin
                            found    = 1'b1;
                            n_credit = n_credit - CREDIT_BITS'(cvc_pkg::CHG_VALUE[k]);
                            coin_out = cvc_pkg::CHG_CODE[k];
                        end
                    end
                    if (n_credit < CREDIT_BITS'(cvc_pkg::MIN_COIN)) begin
                        n_charge  = 1'b0;
                        n_cash    = cvc_pkg::CASH_COLLECT;
                        n_reached = 1'b0;
                    end
                end
            end
        endcase

        o_result.cup_on        = (n_brew == cvc_pkg::BREW_CUP);
        o_result.coffee_on     = (n_brew == cvc_pkg::BREW_COFFEE);
        o_result.milk_on       = (n_brew == cvc_pkg::BREW_MILK);
        o_result.ready_led     = (n_brew == cvc_pkg::BREW_WAIT);
        o_result.change_coin   = coin_out;
        o_result.credit        = 11'(n_credit);
        o_result.enough_credit = n_cr_ready;
    end

endmodule

FILE: hw/rtl/cvc_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on cvc_pkg for the result struct.
module cvc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cvc_pkg::t_result  i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output cvc_pkg::t_result  o_data
);

    logic             r_out_vld;
    logic             r_skid_vld;
    cvc_pkg::t_result r_out;
    cvc_pkg::t_result r_skid;
    logic             take;

    assign take    = r_out_vld & i_ready;
    assign o_space = ~r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_vld || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

FILE: hw/rtl/coffee_vending_controller.sv
// Coffee vending controller, one input transfer per millisecond tick, one
// result per tick: the tick engine computes state in a single pass and the
// result lands in a two-entry output buffer. A tick is taken every cycle
// while the buffer has room; its result is registered, in the skid entry on a stall.
// Settings (price, phase lengths) are written through a plain write port and
// apply to ticks accepted afterwards. Depends on cvc_pkg, cvc_core, cvc_outbuf.
module coffee_vending_controller #(
    parameter int TIME_BITS   = 16,
    parameter int CREDIT_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_button_press,
    input  logic        i_coin_event,
    input  logic [2:0]  i_coin_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_cup_on,
    output logic        o_coffee_on,
    output logic        o_milk_on,
    output logic        o_ready_led,
    output logic [2:0]  o_change_coin,
    output logic [10:0] o_credit,
    output logic        o_enough_credit
);

    cvc_pkg::t_cfg    r_cfg;
    cvc_pkg::t_result core_res;
    cvc_pkg::t_result buf_res;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.price        <= cvc_pkg::PRICE_RST;
            r_cfg.cup_ticks    <= cvc_pkg::CUP_RST;
            r_cfg.coffee_ticks <= cvc_pkg::COFFEE_RST;
            r_cfg.milk_ticks   <= cvc_pkg::MILK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cvc_pkg::CFG_PRICE:  r_cfg.price        <= i_cfg_data[10:0];
                cvc_pkg::CFG_CUP:    r_cfg.cup_ticks    <= i_cfg_data;
                cvc_pkg::CFG_COFFEE: r_cfg.coffee_ticks <= i_cfg_data;
                cvc_pkg::CFG_MILK:   r_cfg.milk_ticks   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_in_valid & o_in_ready;

    cvc_core #(
        .TIME_BITS   (TIME_BITS),
        .CREDIT_BITS (CREDIT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_button_press (i_button_press),
        .i_coin_event   (i_coin_event),
        .i_coin_code    (i_coin_code),
        .i_cfg          (r_cfg),
        .o_result       (core_res)
    );

    cvc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (buf_res)
    );

    assign o_cup_on        = buf_res.cup_on;
    assign o_coffee_on     = buf_res.coffee_on;
    assign o_milk_on       = buf_res.milk_on;
    assign o_ready_led     = buf_res.ready_led;
    assign o_change_coin   = buf_res.change_coin;
    assign o_credit        = buf_res.credit;
    assign o_enough_credit = buf_res.enough_credit;

`ifndef SYNTHESIS
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_cup_on, o_coffee_on, o_milk_on, o_ready_led}) == 1)
        else $error("phase drives not one-hot");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("skid entry held without output entry");

    a_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_change_coin != cvc_pkg::COIN_NONE)
        |-> (o_ready_led && !o_enough_credit && o_change_coin <= cvc_pkg::COIN_200C))
        else $error("change returned outside waiting phase");
`endif

endmodule
